### hdl/fpdf_pkg.sv
// Shared types, constants and helpers for the fixed-point decimal formatter.
// No dependencies; compiled first.
package fpdf_pkg;

  localparam int VALUE_BITS     = 35;
  localparam int VALUE_DIGITS   = 11;   // decimal digits of a 35-bit magnitude
  localparam int MAX_DIGITS_DEF = 10;
  localparam int TOO_BIG_LEN    = 7;

  localparam logic [4:0] LINE_WIDTH_RST = 5'd12;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef enum logic [1:0] {
    BCD_HOLD,
    BCD_LOAD,
    BCD_SHIFT,
    BCD_DROP
  } bcd_cmd_t;

  // width for digit counts and positions
  function automatic int cnt_width(input int n);
    return $clog2(n + 1) + 1;
  endfunction

  function automatic logic [7:0] too_big_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h20;
      3'd4:    c = 8'h62;
      3'd5:    c = 8'h69;
      3'd6:    c = 8'h67;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

### hdl/fpdf_in_if.sv
// Input channel of the decimal formatter: valid/ready plus the number to show.
// Depends on fpdf_pkg.
interface fpdf_in_if import fpdf_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [3:0]                   point_position;
  logic [3:0]                   start_column;
  logic [3:0]                   suffix_length;

  modport source (output valid, value, point_position, start_column, suffix_length,
                  input ready);
  modport sink   (input valid, value, point_position, start_column, suffix_length,
                  output ready);
endinterface

### hdl/fpdf_out_if.sv
// Output channel of the decimal formatter: valid/ready plus one character.
// Depends on fpdf_pkg.
interface fpdf_out_if import fpdf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       kind;
  logic       last;

  modport source (output valid, char_code, kind, last, input ready);
  modport sink   (input valid, char_code, kind, last, output ready);
endinterface

### hdl/fpdf_bcd_unit.sv
// Shared shift unit: bit-serial binary to BCD (shift/add-3), and digit drop
// (divide by ten toward zero). Depends on fpdf_pkg.
module fpdf_bcd_unit import fpdf_pkg::*; #(
  parameter int NUM_DIGITS = VALUE_DIGITS
) (
  input  logic                           clk,
  input  bcd_cmd_t                       cmd,
  input  logic signed [VALUE_BITS-1:0]   value,
  output logic [NUM_DIGITS-1:0][3:0]     digits,
  output logic [cnt_width(NUM_DIGITS)-1:0] nd,
  output logic                           is_zero
);

  localparam int CNT_W = cnt_width(NUM_DIGITS);
  localparam int SH_W  = NUM_DIGITS * 4 + VALUE_BITS;

  logic [NUM_DIGITS-1:0][3:0] bcd;
  logic [VALUE_BITS-1:0]      bin;
  logic [NUM_DIGITS-1:0][3:0] adj;
  logic [SH_W-1:0]            shifted;
  logic [VALUE_BITS-1:0]      raw;
  logic [VALUE_BITS-1:0]      mag;

  assign raw = value;
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
    shifted = {adj, bin} << 1;
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      BCD_LOAD: begin
        bcd <= '0;
        bin <= mag;
      end
      BCD_SHIFT: begin
        bcd <= shifted[SH_W-1:VALUE_BITS];
        bin <= shifted[VALUE_BITS-1:0];
      end
      BCD_DROP: begin
        bcd <= {4'd0, bcd[NUM_DIGITS-1:1]};
      end
      default: begin
        bcd <= bcd;
      end
    endcase
  end

  // count of significant digits, at least one
  always_comb begin
    nd = CNT_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) nd = CNT_W'(i + 1);
    end
  end

  assign is_zero = (bcd == '0);
  assign digits  = bcd;

endmodule

### hdl/fpdf_seq.sv
// Sequencer: drives the BCD unit, fits the text to the line by dropping
// fractional digits, and emits characters. Depends on fpdf_pkg, interfaces.
module fpdf_seq import fpdf_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int NUM_DIGITS = VALUE_DIGITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [4:0]                       line_width,
  fpdf_in_if.sink                          item,
  fpdf_out_if.source                       result,
  output bcd_cmd_t                         cmd,
  input  logic [NUM_DIGITS-1:0][3:0]       digits,
  input  logic [cnt_width(NUM_DIGITS)-1:0] nd,
  input  logic                             is_zero
);

  localparam int CNT_W = cnt_width(NUM_DIGITS);
  localparam int IDX_W = $clog2(NUM_DIGITS);
  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int W_W   = $clog2(NUM_DIGITS + 18) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_FIT,
    S_EMIT,
    S_BIG,
    S_NONE
  } state_t;

  state_t           state;
  logic [BIT_W-1:0] bit_cnt;
  logic [CNT_W-1:0] p;
  logic [3:0]       x;
  logic [3:0]       sfx;
  logic             neg;
  logic [IDX_W-1:0] idx;
  logic             sign_pend;
  logic             dot_pend;
  logic [2:0]       big_idx;
  logic             o_valid;
  logic [7:0]       o_char;
  logic             o_kind;
  logic             o_last;

  logic                  load_ok;
  logic                  emit;
  logic [CNT_W-1:0]      total;
  logic signed [W_W-1:0] avail;
  logic signed [W_W-1:0] w;
  logic                  minus;
  logic                  fit;
  logic                  big_ok;

  assign item.ready       = (state == S_IDLE);
  assign result.valid     = o_valid;
  assign result.char_code = o_char;
  assign result.kind      = o_kind;
  assign result.last      = o_last;

  assign load_ok = !o_valid || result.ready;
  assign emit    = load_ok && (state == S_EMIT || state == S_BIG || state == S_NONE);

  always_comb begin
    minus  = neg && !is_zero;
    total  = ((p != '0) && (nd < p + CNT_W'(1))) ? (p + CNT_W'(1)) : nd;
    avail  = $signed(W_W'(line_width)) - $signed(W_W'(x));
    w      = $signed(W_W'(minus) + W_W'(total) + W_W'(p != '0) + W_W'(sfx));
    fit    = (w <= avail) && (nd <= CNT_W'(MAX_DIGITS)) && (p <= CNT_W'(MAX_DIGITS));
    big_ok = (avail >= $signed(W_W'(TOO_BIG_LEN)));
  end

  always_comb begin
    cmd = BCD_HOLD;
    if (state == S_IDLE && item.valid) begin
      cmd = BCD_LOAD;
    end else if (state == S_CONV) begin
      cmd = BCD_SHIFT;
    end else if (state == S_FIT && !fit && p != '0) begin
      cmd = BCD_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && result.ready && !emit) o_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            p       <= CNT_W'(item.point_position);
            x       <= item.start_column;
            sfx     <= item.suffix_length;
            neg     <= item.value[VALUE_BITS-1];
            bit_cnt <= '0;
            state   <= S_CONV;
          end
        end
        S_CONV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_W'(VALUE_BITS - 1)) state <= S_FIT;
        end
        S_FIT: begin
          if (fit) begin
            idx       <= IDX_W'(total - CNT_W'(1));
            sign_pend <= minus;
            dot_pend  <= 1'b0;
            state     <= S_EMIT;
          end else if (p != '0) begin
            p <= p - CNT_W'(1);
          end else if (big_ok) begin
            big_idx <= '0;
            state   <= S_BIG;
          end else begin
            state <= S_NONE;
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            o_valid <= 1'b1;
            o_kind  <= 1'b0;
            if (sign_pend) begin
              o_char    <= CH_MINUS;
              o_last    <= 1'b0;
              sign_pend <= 1'b0;
            end else if (dot_pend) begin
              o_char   <= CH_DOT;
              o_last   <= 1'b0;
              dot_pend <= 1'b0;
            end else begin
              o_char   <= CH_ZERO + {4'd0, digits[idx]};
              dot_pend <= (p != '0) && (CNT_W'(idx) == p);
              o_last   <= (idx == '0);
              if (idx == '0) begin
                state <= S_IDLE;
              end else begin
                idx <= idx - 1'b1;
              end
            end
          end
        end
        S_BIG: begin
          if (load_ok) begin
            o_valid <= 1'b1;
            o_kind  <= 1'b0;
            o_char  <= too_big_char(big_idx);
            o_last  <= (big_idx == 3'(TOO_BIG_LEN - 1));
            if (big_idx == 3'(TOO_BIG_LEN - 1)) begin
              state <= S_IDLE;
            end else begin
              big_idx <= big_idx + 3'd1;
            end
          end
        end
        S_NONE: begin
          if (load_ok) begin
            o_valid <= 1'b1;
            o_kind  <= 1'b1;
            o_char  <= CH_NONE;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_none_is_single: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_kind) |-> (o_last && o_char == CH_NONE))
    else $error("blank result must be a single zero code");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state == S_CONV && bit_cnt == '0))
    else $error("accepted transaction did not start conversion");

  a_dot_not_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_kind && o_char == CH_DOT) |-> !o_last)
    else $error("dot emitted as final character");

  a_drop_only_fraction: assert property (@(posedge clk) disable iff (rst)
    (cmd == BCD_DROP) |-> (state == S_FIT && p != '0))
    else $error("digit dropped without fractional digit");

endmodule

### hdl/fixed_point_decimal_formatter.sv
// Fixed-point decimal formatter: turns a signed integer with an implied
// decimal point into ASCII characters for one text line. One transaction is
// taken while idle; the block then converts the magnitude to BCD one bit per
// cycle in a shared shift/add-3 unit (a load followed by one shift per bit),
// checks the fit, dropping one fractional digit after each failed check,
// and then sends one character per cycle while the sink is ready.
// A new transaction is accepted as soon as the last character sits in the
// output register. line_width may be written any time the block is idle.
// Depends on fpdf_pkg, fpdf_in_if, fpdf_out_if, fpdf_bcd_unit and fpdf_seq.
module fixed_point_decimal_formatter import fpdf_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fpdf_in_if.sink    item,
  fpdf_out_if.source result,
  input  logic       wr_en,
  input  logic [4:0] wr_data
);

  localparam int NUM_DIGITS = (MAX_DIGITS + 1 > VALUE_DIGITS) ? (MAX_DIGITS + 1)
                                                              : VALUE_DIGITS;
  localparam int CNT_W      = cnt_width(NUM_DIGITS);

  logic [4:0]                 line_width;
  bcd_cmd_t                   cmd;
  logic [NUM_DIGITS-1:0][3:0] digits;
  logic [CNT_W-1:0]           nd;
  logic                       is_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
    end else if (wr_en) begin
      line_width <= wr_data;
    end
  end

  fpdf_bcd_unit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_bcd (
    .clk     (clk),
    .cmd     (cmd),
    .value   (item.value),
    .digits  (digits),
    .nd      (nd),
    .is_zero (is_zero)
  );

  fpdf_seq #(
    .MAX_DIGITS (MAX_DIGITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .item       (item),
    .result     (result),
    .cmd        (cmd),
    .digits     (digits),
    .nd         (nd),
    .is_zero    (is_zero)
  );

endmodule

### verif/tb.sv
// Testbench for fixed_point_decimal_formatter: random and directed numbers in, ASCII characters
// out, each character checked against a behavioral copy of the formatting rules.
// Depends on fpdf_pkg, fpdf_in_if, fpdf_out_if and the formatter RTL.
`timescale 1ns / 1ps

module tb;
  import fpdf_pkg::*;

  localparam int MAX_DIGITS = 10;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS = 28;

  typedef struct packed {
    logic [7:0] code;
    logic       kind;
    logic       last;
  } text_char_t;

  class text_scoreboard;
    text_char_t expected_chars[$];
    logic [4:0] line_width = LINE_WIDTH_RST;
    int         errors = 0;
    string      too_big_txt = "too big";

    task report(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    function void set_width(input logic [4:0] w);
      line_width = w;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void push_char(input logic [7:0] code, input logic kind);
      text_char_t c;
      c.code = code;
      c.kind = kind;
      c.last = 1'b0;
      expected_chars.push_back(c);
    endfunction

    function void mark_last();
      text_char_t c;
      c = expected_chars.pop_back();
      c.last = 1'b1;
      expected_chars.push_back(c);
    endfunction

    // formats one accepted number into the characters the block should send
    function void note_item(input logic signed [VALUE_BITS-1:0] v, input logic [3:0] pp,
                            input logic [3:0] col, input logic [3:0] sfx);
      longint mag;
      longint t;
      bit     neg;
      int     p;
      int     avail;
      int     nd;
      int     total;
      int     w;
      neg   = v < 0;
      mag   = neg ? -longint'(v) : longint'(v);
      p     = int'(pp);
      avail = int'(line_width) - int'(col);
      forever begin
        nd = 1;
        t  = mag;
        while (t >= 10) begin
          t = t / 10;
          nd++;
        end
        total = nd;
        if (p > 0 && total < p + 1) total = p + 1;
        w = ((neg && mag != 0) ? 1 : 0) + total + (p > 0 ? 1 : 0) + int'(sfx);
        if (w <= avail && nd <= MAX_DIGITS && p <= MAX_DIGITS) break;
        if (p > 0) begin
          p--;
          mag = mag / 10;
        end else begin
          if (avail >= TOO_BIG_LEN) begin
            for (int i = 0; i < TOO_BIG_LEN; i++) push_char(too_big_txt[i], 1'b0);
          end else begin
            push_char(CH_NONE, 1'b1);
          end
          mark_last();
          return;
        end
      end
      if (neg && mag != 0) push_char(CH_MINUS, 1'b0);
      for (int i = total - 1; i >= 0; i--) begin
        t = mag;
        repeat (i) t = t / 10;
        push_char(CH_ZERO + 8'(t % 10), 1'b0);
        if (p > 0 && i == p) push_char(CH_DOT, 1'b0);
      end
      mark_last();
    endfunction

    task check_char(input logic [7:0] code, input logic kind, input logic last);
      text_char_t e;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h kind %0b last %0b", code, kind, last));
        return;
      end
      e = expected_chars.pop_front();
      if (code !== e.code) report($sformatf("char_code 0x%02h, want 0x%02h", code, e.code));
      if (kind !== e.kind) report($sformatf("kind %0b, want %0b", kind, e.kind));
      if (last !== e.last) report($sformatf("last %0b, want %0b", last, e.last));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       wr_en;
  logic [4:0] wr_data;
  int         send_idle_pct = 0;
  int         sink_stall_pct = 0;

  text_scoreboard book = new();

  fpdf_in_if  item_ch();
  fpdf_out_if result_ch();

  fixed_point_decimal_formatter DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[fixed_point_decimal_formatter] ERROR");
    $finish;
  end

  // result sink: random back-pressure, every transaction checked
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        book.check_char(result_ch.char_code, result_ch.kind, result_ch.last);
      result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin send_idle_pct = 62; sink_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  sink_stall_pct = 62; end
      default: begin send_idle_pct = 16; sink_stall_pct = 16; end
    endcase
  endtask

  task automatic send_item(input longint v, input int p, input int col, input int sfx);
    logic signed [VALUE_BITS-1:0] val;
    val = VALUE_BITS'(v);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.value          <= val;
    item_ch.point_position <= 4'(p);
    item_ch.start_column   <= 4'(col);
    item_ch.suffix_length  <= 4'(sfx);
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    book.note_item(val, 4'(p), 4'(col), 4'(sfx));
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [4:0] w);
    drain();
    wr_en   <= 1'b1;
    wr_data <= w;
    @(posedge clk);
    wr_en <= 1'b0;
    book.set_width(w);
  endtask

  task automatic send_random();
    longint unsigned r;
    longint          lo;
    longint          hi;
    longint          mag;
    longint          v;
    int              d;
    int              p;
    int              col;
    int              sfx;
    r = {$urandom, $urandom};
    if ($urandom_range(99) < 12) begin
      v = longint'(r);
    end else begin
      d  = $urandom_range(1, 11);
      lo = 1;
      repeat (d - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (d == 1) lo = 0;
      if (hi > 64'd17179869183) hi = 64'd17179869183;
      mag = lo + longint'(r % longint'(hi - lo + 1));
      v   = $urandom_range(1) ? -mag : mag;
    end
    p   = ($urandom_range(99) < 85) ? $urandom_range(0, 10) : $urandom_range(11, 15);
    col = ($urandom_range(99) < 70) ? $urandom_range(0, 5) : $urandom_range(0, 15);
    sfx = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    send_item(v, p, col, sfx);
  endtask

  initial begin
    logic [4:0] widths [9];
    rst                    = 1'b1;
    wr_en                  = 1'b0;
    wr_data                = '0;
    item_ch.valid          = 1'b0;
    item_ch.value          = '0;
    item_ch.point_position = '0;
    item_ch.start_column   = '0;
    item_ch.suffix_length  = '0;
    widths = '{5'd16, 5'd1, 5'd12, 5'd31, 5'd0, 5'd9, 5'(1 + $urandom_range(15)), 5'd14,
               5'(1 + $urandom_range(15))};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset width of 12 columns
    send_item(0, 0, 0, 0);
    send_item(-1, 0, 0, 0);
    send_item(64'sd17179869183, 0, 0, 0);
    send_item(-64'sd17179869184, 0, 0, 0);
    send_item(64'sd9999999999, 0, 0, 0);
    send_item(-64'sd9999999999, 0, 0, 1);
    send_item(3, 4, 0, 0);
    send_item(-7, 1, 9, 0);
    send_item(-12345, 2, 0, 0);
    send_item(5, 15, 0, 0);
    send_item(42, 0, 15, 0);
    send_item(123456, 0, 5, 3);
    send_item(123456, 0, 6, 3);
    send_item(987654321, 5, 0, 15);
    send_item(1234567890, 10, 0, 0);
    write_width(5'd16);
    send_item(-64'sd9999999999, 10, 0, 0);
    send_item(-1234567891, 10, 1, 0);
    send_item(999, 3, 14, 0);
    write_width(5'd1);
    send_item(7, 0, 0, 0);
    send_item(-7, 0, 0, 0);
    write_width(5'd0);
    send_item(0, 0, 0, 0);
    write_width(5'd31);
    send_item(64'sd17179869183, 0, 0, 0);
    send_item(-64'sd17179869184, 10, 0, 0);

    for (int ph = 0; ph < 9; ph++) begin
      write_width(widths[ph]);
      set_mode(ph);
      repeat (PHASE_ITEMS) send_random();
    end

    drain();
    if (book.pending() != 0) book.report($sformatf("%0d chars never sent", book.pending()));
    if (book.errors == 0) begin
      $display("[fixed_point_decimal_formatter] OK");
    end else begin
      $display("[fixed_point_decimal_formatter] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/fpdf_pkg.sv
hdl/fpdf_in_if.sv
hdl/fpdf_out_if.sv
hdl/fpdf_bcd_unit.sv
hdl/fpdf_seq.sv
hdl/fixed_point_decimal_formatter.sv
verif/tb.sv
